[rtl/pssc_pkg.sv]
package pssc_pkg;

  // Event kinds carried by one input beat
  typedef enum logic [1:0] {
    ACT_KEY  = 2'd0,
    ACT_LINE = 2'd1,
    ACT_ADC  = 2'd2,
    ACT_TICK = 2'd3
  } action_e;

  // Key codes; codes 5..7 carry no meaning and fall to the default arm
  typedef enum logic [2:0] {
    KEY_NONE    = 3'd0,
    KEY_UP      = 3'd1,
    KEY_DOWN    = 3'd2,
    KEY_CANCEL  = 3'd3,
    KEY_CONFIRM = 3'd4
  } key_e;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_SET  = 2'd1,
    REPLY_OK   = 2'd2,
    REPLY_ERR  = 2'd3
  } reply_e;

  // Configuration register indexes
  localparam logic [1:0] REG_TRIP_LEVEL   = 2'd0;
  localparam logic [1:0] REG_MAX_SETPOINT = 2'd1;

  localparam logic [11:0] TRIP_RESET     = 12'd3390;
  localparam logic [7:0]  MAX_RESET      = 8'd120;
  localparam logic [7:0]  SETPOINT_RESET = 8'd50;

  // DAC code = tenths * 4095 / 120 = tenths * 273 / 8, exact
  localparam logic [11:0] DAC_FULL        = 12'd4095;
  localparam logic [8:0]  DAC_SLOPE_NUM   = 9'd273;
  localparam int unsigned DAC_SLOPE_SHIFT = 3;

  // ASCII codes used by the line parser
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    action_e     action;
    key_e        key_code;
    logic [7:0]  line_length;
    logic [7:0]  char_zero;
    logic [7:0]  char_one;
    logic [7:0]  char_two;
    logic [7:0]  char_three;
    logic [11:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [7:0] pending;
    logic [7:0] applied;
    logic       edit;
    logic       wr_pend;
  } state_t;

  typedef struct packed {
    logic        dac_write;
    logic [11:0] dac_code;
    logic [7:0]  setpoint_now;
    logic        editing_now;
    reply_e      reply;
    logic        overcurrent;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] clamp_max(logic [8:0] v, logic [7:0] m);
    return (v > {1'b0, m}) ? m : v[7:0];
  endfunction

endpackage

[rtl/pssc_step.sv]
module pssc_step import pssc_pkg::*; (
  input  item_t       item_i,
  input  state_t      state_i,
  input  logic [11:0] trip_level_i,
  input  logic [7:0]  max_setpoint_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [7:0]  ch0, ch1, ch2, ch3;
  logic        is_set_cmd;
  logic        val_ok;
  logic [7:0]  val;
  logic [7:0]  val_clamped;
  logic [16:0] dac_prod;
  logic [13:0] dac_raw;
  logic [11:0] dac_sat;

  // Characters past the line end read as zero
  assign ch0 = (item_i.line_length > 8'd0) ? item_i.char_zero  : 8'd0;
  assign ch1 = (item_i.line_length > 8'd1) ? item_i.char_one   : 8'd0;
  assign ch2 = (item_i.line_length > 8'd2) ? item_i.char_two   : 8'd0;
  assign ch3 = (item_i.line_length > 8'd3) ? item_i.char_three : 8'd0;

  assign is_set_cmd = (item_i.line_length == 8'd3) &&
                      (ch0 == CH_S) && (ch1 == CH_E) && (ch2 == CH_T);

  // Value parser: X.Y or 1X.Y
  always_comb begin
    val_ok = 1'b0;
    val    = 8'd0;
    if (ch1 == CH_DOT) begin
      if ((ch0 >= CH_ONE) && (ch0 <= CH_NINE) && is_digit(ch2)) begin
        val_ok = 1'b1;
        val    = 8'({4'd0, ch0[3:0]} * 8'd10) + {4'd0, ch2[3:0]};
      end
    end else if (ch2 == CH_DOT) begin
      if ((ch0 == CH_ONE) && (ch1 >= CH_ZERO) && (ch1 <= CH_TWO) && is_digit(ch3)) begin
        val_ok = 1'b1;
        val    = 8'd100 + 8'({4'd0, ch1[3:0]} * 8'd10) + {4'd0, ch3[3:0]};
      end
    end
  end

  assign val_clamped = clamp_max({1'b0, val}, max_setpoint_i);

  // DAC scaling of the applied setpoint, saturated to full scale
  assign dac_prod = 17'(state_i.applied) * 17'(DAC_SLOPE_NUM);
  assign dac_raw  = dac_prod[16:DAC_SLOPE_SHIFT];
  assign dac_sat  = (dac_raw > 14'(DAC_FULL)) ? DAC_FULL : dac_raw[11:0];

  // Next state and result for one event
  always_comb begin
    state_o              = state_i;
    result_o.dac_write   = 1'b0;
    result_o.dac_code    = 12'd0;
    result_o.reply       = REPLY_NONE;
    result_o.overcurrent = 1'b0;
    case (item_i.action)
      ACT_KEY: begin
        case (item_i.key_code)
          KEY_UP: begin
            state_o.edit    = 1'b1;
            state_o.pending = clamp_max({1'b0, state_i.pending} + 9'd1, max_setpoint_i);
          end
          KEY_DOWN: begin
            state_o.edit    = 1'b1;
            state_o.pending = clamp_max((state_i.pending == 8'd0) ? 9'd0 :
                                        {1'b0, state_i.pending} - 9'd1, max_setpoint_i);
          end
          KEY_CANCEL: begin
            state_o.pending = state_i.applied;
            state_o.edit    = 1'b0;
          end
          KEY_CONFIRM: begin
            state_o.wr_pend = 1'b1;
            state_o.edit    = 1'b0;
            state_o.applied = state_i.pending;
          end
          default: ;
        endcase
      end
      ACT_LINE: begin
        if (is_set_cmd) begin
          result_o.reply = REPLY_SET;
          state_o.edit   = 1'b1;
        end else if (state_i.edit) begin
          state_o.edit = 1'b0;
          if (val_ok) begin
            state_o.pending = val_clamped;
            state_o.applied = val_clamped;
            state_o.wr_pend = 1'b1;
            result_o.reply  = REPLY_OK;
          end else begin
            state_o.pending = state_i.applied;
            result_o.reply  = REPLY_ERR;
          end
        end else begin
          result_o.reply = REPLY_ERR;
        end
      end
      ACT_ADC: begin
        if (item_i.adc_sample >= trip_level_i) begin
          state_o.pending      = 8'd0;
          state_o.applied      = 8'd0;
          result_o.dac_write   = 1'b1;
          result_o.overcurrent = 1'b1;
        end
      end
      ACT_TICK: begin
        if (state_i.wr_pend) begin
          result_o.dac_write = 1'b1;
          result_o.dac_code  = dac_sat;
          state_o.wr_pend    = 1'b0;
        end
      end
      default: ;
    endcase
    result_o.setpoint_now = state_o.pending;
    result_o.editing_now  = state_o.edit;
  end

endmodule

[rtl/power_supply_setpoint_controller.sv]
// Setpoint controller for a DAC-driven supply, voltages in tenths of a volt.
// Input channel (in_valid_i/in_ready_o): one beat is one event, a key press,
// a received text line (length plus first four characters), an ADC current
// sample or a DAC service tick, chosen by action_i.
// Output channel (out_valid_o/out_ready_i): exactly one result beat per event
// with the DAC write strobe and code, the pending setpoint, edit mode, the
// text reply and the overcurrent flag.
// Config port: cfg_we_i writes cfg_data_i into register cfg_addr_i
// (0 trip level, 1 max setpoint); write only while no event is in flight.
// Each result beat comes in the cycle after its event; one event is taken
// per cycle, bounded only by the single result register: a new beat is taken
// whenever that register is empty or is being drained in the same cycle.
// If the receiver stalls, the result is held and in_ready_o drops until it
// is taken. Reset restores trip level 3390, max setpoint 120, both setpoints
// 50, edit mode off, a DAC write pending, and empties the result register.
module power_supply_setpoint_controller import pssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [2:0]  key_code_i,
  input  logic [7:0]  line_length_i,
  input  logic [7:0]  char_zero_i,
  input  logic [7:0]  char_one_i,
  input  logic [7:0]  char_two_i,
  input  logic [7:0]  char_three_i,
  input  logic [11:0] adc_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        dac_write_o,
  output logic [11:0] dac_code_o,
  output logic [7:0]  setpoint_now_o,
  output logic        editing_now_o,
  output logic [1:0]  reply_o,
  output logic        overcurrent_o
);

  logic [11:0] trip_q;
  logic [7:0]  max_q;
  state_t      state_q, state_d;
  result_t     res_q, res_d;
  logic        out_valid_q;
  item_t       item;
  logic        in_fire;

  assign item = '{
    action:      action_e'(action_i),
    key_code:    key_e'(key_code_i),
    line_length: line_length_i,
    char_zero:   char_zero_i,
    char_one:    char_one_i,
    char_two:    char_two_i,
    char_three:  char_three_i,
    adc_sample:  adc_sample_i
  };

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  pssc_step u_step (
    .item_i         (item),
    .state_i        (state_q),
    .trip_level_i   (trip_q),
    .max_setpoint_i (max_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q <= TRIP_RESET;
      max_q  <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TRIP_LEVEL:   trip_q <= cfg_data_i;
        REG_MAX_SETPOINT: max_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Controller state advances once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pending: SETPOINT_RESET, applied: SETPOINT_RESET,
                   edit: 1'b0, wr_pend: 1'b1};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dac_write_o    = res_q.dac_write;
  assign dac_code_o     = res_q.dac_code;
  assign setpoint_now_o = res_q.setpoint_now;
  assign editing_now_o  = res_q.editing_now;
  assign reply_o        = res_q.reply;
  assign overcurrent_o  = res_q.overcurrent;

endmodule

[rtl/pssc_checker.sv]
module pssc_checker import pssc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        dac_write_o,
  input logic [11:0] dac_code_o,
  input logic [7:0]  setpoint_now_o,
  input logic [1:0]  reply_o,
  input logic        overcurrent_o
);

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Every accepted event yields a result beat on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted event produced no result");

  // Empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A trip forces a zero write and a zero setpoint
  a_trip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overcurrent_o |->
      dac_write_o && (dac_code_o == 12'd0) && (setpoint_now_o == 8'd0))
    else $error("overcurrent result not a zero write");

  // Text replies never coincide with DAC activity
  a_reply_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reply_o != REPLY_NONE) |-> !dac_write_o && !overcurrent_o)
    else $error("reply together with DAC write");

endmodule

bind power_supply_setpoint_controller pssc_checker u_pssc_checker (.*);
